// ===== rtl/core/olis_pkg.sv =====
// ----------------------------------------------------------------------------
// olis_pkg
// Shared types and constants for the ordered list block: command codes,
// transfer payloads and the control word broadcast along the cell chain.
// ----------------------------------------------------------------------------
package olis_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;
    localparam int CMD_W     = 3;
    localparam int CAP_W     = 7;
    localparam int POS_W     = 7;
    localparam int FOUND_W   = 6;
    localparam int CAP_RESET = 64;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_item;

    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] removed_value;
        logic [FOUND_W-1:0]      found_position;
        logic [CAP_W-1:0]        entry_count;
        logic                    is_empty;
        logic                    is_full;
    } t_result;

    // Operation carried out by every cell in the execute cycle
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SEARCH = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic             exec;
        t_cell_op         op;
        logic [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== rtl/core/olis_cell.sv =====
// ----------------------------------------------------------------------------
// olis_cell
// One list slot. Shifts toward either neighbor, loads the broadcast value,
// and records the removed entry or its own index on a first search match.
// ----------------------------------------------------------------------------
module olis_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  olis_pkg::t_cell_ctl            i_ctl,
    input  logic [IDX_W-1:0]               i_pos,
    input  logic [CNT_W-1:0]               i_count,
    input  logic [olis_pkg::VAL_W-1:0]     i_left,
    input  logic [olis_pkg::VAL_W-1:0]     i_right,
    input  logic                           i_before,
    output logic                           o_before,
    output logic                           o_hit,
    output logic [olis_pkg::VAL_W-1:0]     o_res,
    output logic [olis_pkg::VAL_W-1:0]     o_data
);
    import olis_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

    logic [VAL_W-1:0] r_data, n_data;
    logic [VAL_W-1:0] r_res,  n_res;
    logic             r_hit,  n_hit;
    logic             w_match;

    // Only live entries take part in a search
    assign w_match  = (r_data == i_ctl.value) && (MY_CNT < i_count);
    assign o_before = i_before | ((i_ctl.op == OP_SEARCH) & w_match);

    always_comb begin
        n_data = r_data;
        n_hit  = 1'b0;
        n_res  = '0;
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (MY_IDX > i_pos) begin
                    n_data = i_left;
                end else if (MY_IDX == i_pos) begin
                    n_data = i_ctl.value;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    n_data = i_right;
                end
                if (MY_IDX == i_pos) begin
                    n_hit = 1'b1;
                    n_res = r_data;
                end
            end
            OP_SEARCH: begin
                if (w_match && !i_before) begin
                    n_hit = 1'b1;
                    n_res = VAL_W'(IDX);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_data <= n_data;
            r_res  <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.exec) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit  = r_hit;
    assign o_res  = r_res;
    assign o_data = r_data;

endmodule

// ===== rtl/core/olis_collect.sv =====
// ----------------------------------------------------------------------------
// olis_collect
// Merges the per-cell result words. At most one cell reports a hit, so an
// OR over the masked words yields its removed value or its index.
// ----------------------------------------------------------------------------
module olis_collect #(
    parameter int DEPTH = olis_pkg::DEPTH_DEF
) (
    input  logic [DEPTH-1:0]               i_hits,
    input  logic [olis_pkg::VAL_W-1:0]     i_res [DEPTH],
    output logic                           o_any,
    output logic [olis_pkg::VAL_W-1:0]     o_word
);
    import olis_pkg::*;

    always_comb begin
        o_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            o_word = o_word | (i_hits[k] ? i_res[k] : '0);
        end
    end

    assign o_any = |i_hits;

endmodule

// ===== rtl/core/ordered_list_insert_remove_search_top.sv =====
// A command is accepted in the idle state, executed in the cell chain in the
// execute state, and its result word is registered for output in the collect
// state, which waits while the result side stalls; only idle takes commands.
// Reset: entry count zero, capacity min(64, DEPTH), stored entries undefined.
// A capacity write also empties the list.
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_search_top
// Ordered list of signed values held in a chain of cells with shift insert,
// shift remove, first-match search, append and clear.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_search_top #(
    parameter int DEPTH = olis_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [olis_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  olis_pkg::t_item             i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output olis_pkg::t_result           o_out_result
);
    import olis_pkg::*;

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_EXEC    = 3'b010,
        S_COLLECT = 3'b100
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_cap, n_cap;
    logic             r_out_valid;
    t_item            r_item;
    t_result          r_out;
    logic             r_ok, n_ok;
    logic             r_is_search, r_is_remove;

    t_cell_ctl        w_ctl;
    logic [IDX_W-1:0] w_pos;
    logic             w_accept, w_load, w_full;
    logic [DEPTH-1:0] w_hits;
    logic [VAL_W-1:0] w_res    [DEPTH];
    logic [VAL_W-1:0] w_data   [DEPTH];
    logic [VAL_W-1:0] w_left   [DEPTH];
    logic [VAL_W-1:0] w_right  [DEPTH];
    logic             w_before [DEPTH+1];
    logic             w_any;
    logic [VAL_W-1:0] w_word;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load     = (r_state == S_COLLECT) && (!r_out_valid || !i_out_stall);
    assign w_full     = (r_count >= r_cap);

    // Capacity write: zero acts as one, anything above DEPTH as DEPTH
    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = CNT_W'(1);
        end else if (32'(i_cfg_data) > 32'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = CNT_W'(i_cfg_data);
        end
    end

    // Command decode for the execute cycle
    always_comb begin
        w_ctl.exec  = (r_state == S_EXEC);
        w_ctl.op    = OP_NONE;
        w_ctl.value = VAL_W'(r_item.item_value);
        w_pos       = IDX_W'(r_item.position);
        n_ok        = 1'b0;
        n_count     = r_count;
        unique case (r_item.command)
            CMD_APPEND: begin
                w_pos = IDX_W'(r_count);
                if (!w_full) begin
                    n_ok     = 1'b1;
                    w_ctl.op = OP_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                if (!w_full && (32'(r_item.position) <= 32'(r_count))) begin
                    n_ok     = 1'b1;
                    w_ctl.op = OP_INSERT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (32'(r_item.position) < 32'(r_count)) begin
                    n_ok     = 1'b1;
                    w_ctl.op = OP_REMOVE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            CMD_SEARCH: begin
                w_ctl.op = OP_SEARCH;
            end
            CMD_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CNT_W'(CAP_RST);
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_cap   <= n_cap;
                r_count <= '0;
            end else if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_COLLECT;
                end
                S_COLLECT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
        if (r_state == S_EXEC) begin
            r_ok        <= n_ok;
            r_is_search <= (r_item.command == CMD_SEARCH);
            r_is_remove <= (r_item.command == CMD_REMOVE);
        end
        if (w_load) begin
            r_out.ok             <= r_is_search ? w_any : r_ok;
            r_out.removed_value  <= r_is_remove ? signed'(w_word) : '0;
            r_out.found_position <= r_is_search ? FOUND_W'(w_word) : '0;
            r_out.entry_count    <= CAP_W'(r_count);
            r_out.is_empty       <= (r_count == '0);
            r_out.is_full        <= w_full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

    assign w_before[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid_r
            assign w_right[g] = w_data[g+1];
        end

        olis_cell #(
            .IDX   (g),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_pos    (w_pos),
            .i_count  (r_count),
            .i_left   (w_left[g]),
            .i_right  (w_right[g]),
            .i_before (w_before[g]),
            .o_before (w_before[g+1]),
            .o_hit    (w_hits[g]),
            .o_res    (w_res[g]),
            .o_data   (w_data[g])
        );
    end

    olis_collect #(
        .DEPTH (DEPTH)
    ) u_collect (
        .i_hits (w_hits),
        .i_res  (w_res),
        .o_any  (w_any),
        .o_word (w_word)
    );

`ifndef SYNTHESIS
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted command not executed");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COLLECT) |-> $onehot0(w_hits))
        else $error("more than one cell reports a hit");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_COLLECT))
        else $error("result offered without a collect cycle");
`endif

endmodule

// ===== tb/tb_ordered_list_insert_remove_search_top.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_remove_search_top
// Self-checking bench for the ordered list block. A queue of commands feeds
// a driver that idles in random bursts, while the result side stalls in
// random bursts (neither in the final quiet phase). Every accepted command
// runs through a list model kept in the bench, and each result transfer is
// checked field by field against the oldest predicted result. Capacity is
// rewritten between phases, only once the block has drained.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_remove_search_top;
    import olis_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 6;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [CAP_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_item             i_in_item  = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_result           o_out_result;

    ordered_list_insert_remove_search_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // List model state
    logic signed [VAL_W-1:0] list_mem [0:LIST_DEPTH-1];
    int                      list_len;
    int                      list_cap;

    // Stimulus-side count tracking, used only to aim positions
    int                      gen_cnt;
    int                      gen_cap;
    logic [VAL_W-1:0]        val_pool [0:7];
    logic [VAL_W-1:0]        last_wide;

    t_item                   pending_cmds [$];
    t_result                 expected_results [$];
    int                      pushed_cnt;
    int                      taken_cnt;
    int                      err_cnt;
    int                      cycle_cnt;
    bit                      in_taken;
    bit                      quiet;
    int                      in_gap;
    int                      out_hold;

    function automatic int clamp_cap(int v);
        if (v == 0) return 1;
        if (v > LIST_DEPTH) return LIST_DEPTH;
        return v;
    endfunction

    function automatic t_result list_step(t_item it);
        t_result r;
        int      i;
        int      pos;
        bit      full;
        r    = '0;
        pos  = int'(it.position);
        full = (list_len >= list_cap);
        case (it.command)
            CMD_APPEND: begin
                if (!full && list_len < LIST_DEPTH) begin
                    list_mem[list_len] = it.item_value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (!full && pos <= list_len && list_len < LIST_DEPTH) begin
                    for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
                    list_mem[pos] = it.item_value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (list_len != 0 && pos < list_len) begin
                    r.removed_value = list_mem[pos];
                    for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            CMD_SEARCH: begin
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == it.item_value) begin
                        r.found_position = i[FOUND_W-1:0];
                        r.ok = 1'b1;
                        break;
                    end
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.entry_count = list_len[CAP_W-1:0];
        r.is_empty    = (list_len == 0);
        r.is_full     = (list_len >= list_cap);
        return r;
    endfunction

    function automatic t_item mk_cmd(logic [CMD_W-1:0] cmd, int pos, logic [VAL_W-1:0] val);
        t_item it;
        it.command    = cmd;
        it.position   = pos[POS_W-1:0];
        it.item_value = val;
        return it;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) return val_pool[$urandom_range(0, 7)];
        last_wide = $urandom;
        return last_wide;
    endfunction

    // Mostly well-formed commands aimed at the current fill; the rest is noise
    function automatic t_item gen_cmd(int add_pct);
        t_item it;
        int    r;
        it            = '0;
        r             = $urandom_range(0, 99);
        it.item_value = pick_value();
        if (r < add_pct) begin
            it.command  = $urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND;
            it.position = POS_W'($urandom_range(0, gen_cnt));
        end else if (r < add_pct + 20) begin
            it.command  = CMD_REMOVE;
            it.position = (gen_cnt > 0) ? POS_W'($urandom_range(0, gen_cnt - 1)) : '0;
        end else if (r < add_pct + 35) begin
            it.command = CMD_SEARCH;
            if ($urandom_range(0, 2) == 0) it.item_value = last_wide;
        end else if (r < add_pct + 38) begin
            it.command = CMD_CLEAR;
        end else begin
            it.command  = CMD_W'($urandom_range(0, 7));
            it.position = POS_W'($urandom_range(0, 127));
        end
        return it;
    endfunction

    task automatic queue_cmd(t_item it);
        pending_cmds.push_back(it);
        pushed_cnt++;
        case (it.command)
            CMD_APPEND: if (gen_cnt < gen_cap) gen_cnt++;
            CMD_INSERT: if (gen_cnt < gen_cap && int'(it.position) <= gen_cnt) gen_cnt++;
            CMD_REMOVE: if (int'(it.position) < gen_cnt) gen_cnt--;
            CMD_CLEAR:  gen_cnt = 0;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (taken_cnt != pushed_cnt || expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_capacity(int v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[CAP_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        list_cap = clamp_cap(v & 'h7f);
        list_len = 0;
        gen_cap  = list_cap;
        gen_cnt  = 0;
    endtask

    // Command driver and result-side stall, both changing on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                in_taken = 1'b0;
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    i_in_item  <= pending_cmds.pop_front();
                    i_in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_hold = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Result check and prediction on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                if (o_out_valid && !i_out_stall) begin
                    if (expected_results.size() == 0) begin
                        if (err_cnt < 10)
                            $display("unexpected result transfer: ok=%0d cnt=%0d",
                                     o_out_result.ok, o_out_result.entry_count);
                        err_cnt++;
                    end else begin
                        t_result exp_r;
                        exp_r = expected_results.pop_front();
                        if (o_out_result.ok !== exp_r.ok ||
                            o_out_result.removed_value !== exp_r.removed_value ||
                            o_out_result.found_position !== exp_r.found_position ||
                            o_out_result.entry_count !== exp_r.entry_count ||
                            o_out_result.is_empty !== exp_r.is_empty ||
                            o_out_result.is_full !== exp_r.is_full) begin
                            if (err_cnt < 10) begin
                                $display("mismatch exp ok=%0d rem=%0d pos=%0d cnt=%0d emp=%0d full=%0d",
                                         exp_r.ok, exp_r.removed_value,
                                         exp_r.found_position, exp_r.entry_count,
                                         exp_r.is_empty, exp_r.is_full);
                                $display("         got ok=%0d rem=%0d pos=%0d cnt=%0d emp=%0d full=%0d",
                                         o_out_result.ok, o_out_result.removed_value,
                                         o_out_result.found_position,
                                         o_out_result.entry_count,
                                         o_out_result.is_empty, o_out_result.is_full);
                            end
                            err_cnt++;
                        end
                    end
                end
                if (i_in_valid && !o_in_stall) begin
                    expected_results.push_back(list_step(i_in_item));
                    taken_cnt++;
                    in_taken = 1'b1;
                end
            end
        end
    end

    initial begin
        int i;
        list_len   = 0;
        list_cap   = clamp_cap(CAP_RESET);
        gen_cnt    = 0;
        gen_cap    = list_cap;
        pushed_cnt = 0;
        taken_cnt  = 0;
        err_cnt    = 0;
        cycle_cnt  = 0;
        in_taken   = 1'b0;
        quiet      = 1'b0;
        in_gap     = 0;
        out_hold   = 0;
        for (i = 0; i < 8; i++) val_pool[i] = $urandom;
        val_pool[0] = 32'h7fff_ffff;
        val_pool[1] = 32'h8000_0000;
        val_pool[2] = 32'hffff_ffff;
        val_pool[3] = 32'h0000_0000;
        last_wide   = val_pool[4];

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset capacity, empty-list rejects, extremes, bad positions
        queue_cmd(mk_cmd(CMD_REMOVE, 0, 32'h1234_5678));
        queue_cmd(mk_cmd(CMD_SEARCH, 0, 32'h0000_0000));
        queue_cmd(mk_cmd(CMD_APPEND, 0, 32'h7fff_ffff));
        queue_cmd(mk_cmd(CMD_APPEND, 127, 32'h8000_0000));
        queue_cmd(mk_cmd(CMD_INSERT, 0, 32'hffff_ffff));
        queue_cmd(mk_cmd(CMD_INSERT, 3, 32'h0000_0000));   // position equal to count
        queue_cmd(mk_cmd(CMD_INSERT, 5, 32'h5555_5555));   // beyond count
        queue_cmd(mk_cmd(CMD_INSERT, 127, 32'haaaa_aaaa));
        queue_cmd(mk_cmd(CMD_SEARCH, 0, 32'h8000_0000));
        queue_cmd(mk_cmd(CMD_SEARCH, 64, 32'h0001_e240));
        queue_cmd(mk_cmd(CMD_REMOVE, 4, 32'h0));
        queue_cmd(mk_cmd(CMD_REMOVE, 127, 32'h0));
        queue_cmd(mk_cmd(CMD_REMOVE, 1, 32'h0));
        queue_cmd(mk_cmd(CMD_RSVD5, 0, 32'hffff_ffff));
        queue_cmd(mk_cmd(CMD_RSVD7, 127, 32'h0));
        queue_cmd(mk_cmd(CMD_CLEAR, 0, 32'h0));
        queue_cmd(mk_cmd(CMD_SEARCH, 0, 32'hffff_ffff));

        // Zero capacity behaves as one entry
        write_capacity(0);
        queue_cmd(mk_cmd(CMD_APPEND, 0, 32'h0000_0005));
        queue_cmd(mk_cmd(CMD_APPEND, 0, 32'h0000_0006));
        queue_cmd(mk_cmd(CMD_INSERT, 0, 32'h0000_0007));
        queue_cmd(mk_cmd(CMD_SEARCH, 0, 32'h0000_0005));
        queue_cmd(mk_cmd(CMD_REMOVE, 0, 32'h0));

        // Random phases over a range of capacities; oversized clamps to depth
        write_capacity(127);
        repeat (150) queue_cmd(gen_cmd(58));
        write_capacity(1);
        repeat (40) queue_cmd(gen_cmd(45));
        write_capacity(65);
        repeat (60) queue_cmd(gen_cmd(55));
        write_capacity($urandom_range(2, 10));
        repeat (100) queue_cmd(gen_cmd(45));
        write_capacity(64);
        quiet = 1'b1;
        repeat (150) queue_cmd(gen_cmd(50));

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (err_cnt == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
